FILE: src/tlge_pkg.sv
// package: board sizes, opcodes, controller states, command structs and the life rule
`timescale 1ns / 1ps
`default_nettype none
package tlge_pkg;

  localparam int COLS  = 20;
  localparam int ROWS  = 18;
  localparam int COL_W = 5;
  localparam int ROW_W = 5;
  localparam int OP_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 3'd0,
    OP_TOGGLE = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_STEP   = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_L,
    ST_LOAD_M,
    ST_LOAD_R,
    ST_STEP,
    ST_CLEAR,
    ST_SINGLE
  } state_t;

  typedef struct packed {
    logic             load_left;
    logic             load_mid;
    logic             load_right;
    logic             step_col;
    logic             clear_col;
    logic             single;
    logic [COL_W-1:0] rd_idx;
    logic [COL_W-1:0] col;
    logic             wrap;
    logic             last;
    op_t              op;
    logic [ROW_W-1:0] row;
    logic             value;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // b3/s23 on one column, rows wrap
  function automatic logic [ROWS-1:0] life_col(input logic [ROWS-1:0] l,
                                               input logic [ROWS-1:0] m,
                                               input logic [ROWS-1:0] r);
    logic [ROWS-1:0] nxt;
    logic [3:0]      n;
    int              up;
    int              dn;
    nxt = '0;
    for (int y = 0; y < ROWS; y++) begin
      up = (y + ROWS - 1) % ROWS;
      dn = (y + 1) % ROWS;
      n = 4'(l[up]) + 4'(l[y]) + 4'(l[dn]) + 4'(m[up]) + 4'(m[dn])
        + 4'(r[up]) + 4'(r[y]) + 4'(r[dn]);
      nxt[y] = (n == 4'd3) || (m[y] && (n == 4'd2));
    end
    return nxt;
  endfunction

endpackage
`default_nettype wire

FILE: src/tlge_cmd_if.sv
// interface: request channel into the engine
`timescale 1ns / 1ps
`default_nettype none
interface tlge_cmd_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              op;
  logic [4:0]              col_x;
  logic [4:0]              row_y;
  logic                    cell_value;

  modport source (output valid, output op, output col_x, output row_y, output cell_value,
                  input ready);
  modport sink   (input valid, input op, input col_x, input row_y, input cell_value,
                  output ready);
endinterface
`default_nettype wire

FILE: src/tlge_res_if.sv
// interface: result channel out of the engine
`timescale 1ns / 1ps
`default_nettype none
interface tlge_res_if;
  logic        valid;
  logic        ready;
  logic [4:0]  out_col;
  logic [17:0] col_bits;
  logic [17:0] changed_bits;
  logic        last;

  modport source (output valid, output out_col, output col_bits, output changed_bits,
                  output last, input ready);
  modport sink   (input valid, input out_col, input col_bits, input changed_bits,
                  input last, output ready);
endinterface
`default_nettype wire

FILE: src/toroidal_life_generation_engine.sv
// top level: life engine on a wrapped 20 x 18 board
//
//   channel  dir  fields                                      handshake
//   cmd      in   op, col_x, row_y, cell_value                valid & ready
//   res      out  out_col, col_bits, changed_bits, last       valid & ready
//
// step: after the accept, 3 window loads, then a sweep over the 20 columns, one result per column
// clear: after the accept, a sweep over the 20 columns, one result each; write, toggle, read: one result
// the single board read port and the one-column life unit set this sequencing
// a stalled result register holds the sweep where it is; it resumes once res is taken
// rst is synchronous: board cleared, no result pending, ready for a request once rst is low
`timescale 1ns / 1ps
`default_nettype none
module toroidal_life_generation_engine (
  input  wire logic  clk,
  input  wire logic  rst,
  tlge_cmd_if.sink   cmd,
  tlge_res_if.source res
);

  tlge_pkg::dp_cmd_t  dp_cmd;
  tlge_pkg::dp_stat_t dp_stat;

  tlge_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (cmd),
    .cmd  (dp_cmd),
    .stat (dp_stat)
  );

  tlge_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (dp_cmd),
    .stat (dp_stat),
    .res  (res)
  );

endmodule
`default_nettype wire

FILE: src/tlge_ctrl.sv
// controller: request capture and sequencing of loads, sweeps and single-cell ops
`timescale 1ns / 1ps
`default_nettype none
module tlge_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  tlge_cmd_if.sink               req,
  output tlge_pkg::dp_cmd_t      cmd,
  input  wire tlge_pkg::dp_stat_t stat
);

  tlge_pkg::state_t             state, state_next;
  logic [tlge_pkg::COL_W-1:0]   col, col_next;
  tlge_pkg::op_t                op_q;
  logic [tlge_pkg::COL_W-1:0]   col_q;
  logic [tlge_pkg::ROW_W-1:0]   row_q;
  logic                         val_q;
  logic                         accept;
  logic                         col_ok;
  logic                         row_ok;
  logic [tlge_pkg::COL_W:0]     ahead;
  logic                         col_end;

  assign accept = req.valid && req.ready;
  assign col_ok = {1'b0, req.col_x} < (tlge_pkg::COL_W + 1)'(tlge_pkg::COLS);
  assign row_ok = {1'b0, req.row_y} < (tlge_pkg::ROW_W + 1)'(tlge_pkg::ROWS);
  assign ahead  = {1'b0, col} + (tlge_pkg::COL_W + 1)'(2);
  assign col_end = col == tlge_pkg::COL_W'(tlge_pkg::COLS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlge_pkg::ST_IDLE;
      col   <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= tlge_pkg::op_t'(req.op);
      col_q <= req.col_x;
      row_q <= req.row_y;
      val_q <= req.cell_value;
    end
  end

  always_comb begin
    state_next = state;
    col_next   = col;
    req.ready  = 1'b0;
    cmd        = '0;
    cmd.op     = op_q;
    cmd.row    = row_q;
    cmd.value  = val_q;
    cmd.col    = col;
    cmd.last   = col_end;
    cmd.wrap   = ahead == (tlge_pkg::COL_W + 1)'(tlge_pkg::COLS);
    cmd.rd_idx = col;
    unique case (state)
      tlge_pkg::ST_IDLE: begin
        // no request taken while reset is held
        req.ready = !rst;
        col_next  = '0;
        if (req.valid) begin
          unique case (tlge_pkg::op_t'(req.op))
            tlge_pkg::OP_WRITE, tlge_pkg::OP_TOGGLE: begin
              if (col_ok && row_ok) state_next = tlge_pkg::ST_SINGLE;
            end
            tlge_pkg::OP_READ: begin
              if (col_ok) state_next = tlge_pkg::ST_SINGLE;
            end
            tlge_pkg::OP_CLEAR: state_next = tlge_pkg::ST_CLEAR;
            tlge_pkg::OP_STEP:  state_next = tlge_pkg::ST_LOAD_L;
            default:            state_next = tlge_pkg::ST_IDLE;
          endcase
        end
      end
      tlge_pkg::ST_LOAD_L: begin
        cmd.rd_idx    = tlge_pkg::COL_W'(tlge_pkg::COLS - 1);
        cmd.load_left = 1'b1;
        state_next    = tlge_pkg::ST_LOAD_M;
      end
      tlge_pkg::ST_LOAD_M: begin
        cmd.rd_idx   = '0;
        cmd.load_mid = 1'b1;
        state_next   = tlge_pkg::ST_LOAD_R;
      end
      tlge_pkg::ST_LOAD_R: begin
        cmd.rd_idx     = tlge_pkg::COL_W'(1);
        cmd.load_right = 1'b1;
        state_next     = tlge_pkg::ST_STEP;
      end
      tlge_pkg::ST_STEP: begin
        // fetch two columns ahead to refill the window
        if (ahead >= (tlge_pkg::COL_W + 1)'(tlge_pkg::COLS))
          cmd.rd_idx = tlge_pkg::COL_W'(ahead - (tlge_pkg::COL_W + 1)'(tlge_pkg::COLS));
        else
          cmd.rd_idx = tlge_pkg::COL_W'(ahead);
        if (stat.out_free) begin
          cmd.step_col = 1'b1;
          if (col_end) state_next = tlge_pkg::ST_IDLE;
          else         col_next   = col + tlge_pkg::COL_W'(1);
        end
      end
      tlge_pkg::ST_CLEAR: begin
        if (stat.out_free) begin
          cmd.clear_col = 1'b1;
          if (col_end) state_next = tlge_pkg::ST_IDLE;
          else         col_next   = col + tlge_pkg::COL_W'(1);
        end
      end
      tlge_pkg::ST_SINGLE: begin
        cmd.rd_idx = col_q;
        cmd.col    = col_q;
        cmd.last   = 1'b1;
        if (stat.out_free) begin
          cmd.single = 1'b1;
          state_next = tlge_pkg::ST_IDLE;
        end
      end
      default: state_next = tlge_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/tlge_datapath.sv
// datapath: board registers, three-column window, life rule and result register
`timescale 1ns / 1ps
`default_nettype none
module tlge_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tlge_pkg::dp_cmd_t  cmd,
  output tlge_pkg::dp_stat_t      stat,
  tlge_res_if.source              res
);

  logic [tlge_pkg::ROWS-1:0] board [tlge_pkg::COLS];
  logic [tlge_pkg::ROWS-1:0] left, mid, right, first;
  logic [tlge_pkg::ROWS-1:0] rd_col;
  logic [tlge_pkg::ROWS-1:0] gen_col;
  logic [tlge_pkg::ROWS-1:0] bit_mask;
  logic [tlge_pkg::ROWS-1:0] single_col;
  logic                      out_valid;
  logic                      out_free;

  assign rd_col   = board[cmd.rd_idx];
  assign gen_col  = tlge_pkg::life_col(left, mid, right);
  assign bit_mask = tlge_pkg::ROWS'(1) << cmd.row;
  assign out_free = !out_valid || res.ready;
  assign stat.out_free = out_free;

  always_comb begin
    unique case (cmd.op)
      tlge_pkg::OP_WRITE:  single_col = cmd.value ? (rd_col | bit_mask) : (rd_col & ~bit_mask);
      tlge_pkg::OP_TOGGLE: single_col = rd_col ^ bit_mask;
      default:             single_col = rd_col;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tlge_pkg::COLS; i++) board[i] <= '0;
    end else if (cmd.step_col) begin
      board[cmd.col] <= gen_col;
    end else if (cmd.clear_col) begin
      board[cmd.col] <= '0;
    end else if (cmd.single) begin
      board[cmd.col] <= single_col;
    end
  end

  // sliding window over old columns; column 0 is kept aside for the wrap
  always_ff @(posedge clk) begin
    if (cmd.load_left) left <= rd_col;
    if (cmd.load_mid) begin
      mid   <= rd_col;
      first <= rd_col;
    end
    if (cmd.load_right) right <= rd_col;
    if (cmd.step_col) begin
      left  <= mid;
      mid   <= right;
      right <= cmd.wrap ? first : rd_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step_col || cmd.clear_col || cmd.single) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_col) begin
      res.col_bits     <= gen_col;
      res.changed_bits <= mid ^ gen_col;
    end else if (cmd.clear_col) begin
      res.col_bits     <= '0;
      res.changed_bits <= rd_col;
    end else if (cmd.single) begin
      res.col_bits     <= single_col;
      res.changed_bits <= rd_col ^ single_col;
    end
    if (cmd.step_col || cmd.clear_col || cmd.single) begin
      res.out_col <= cmd.col;
      res.last    <= cmd.last;
    end
  end

  assign res.valid = out_valid;

endmodule
`default_nettype wire

FILE: src/tlge_checker.sv
// checker: port-level properties of the life engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module tlge_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [4:0]  res_col,
  input wire logic [17:0] res_bits,
  input wire logic        res_last
);

  // a held result keeps its column and its bits
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_bits) && $stable(res_col))
    else $error("result changed while stalled");

  // a result that is not the last of its request means a sweep is still running
  a_busy_mid_sweep: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !cmd_ready)
    else $error("request taken during a sweep");

  // idle engine with no request stays ready
  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    cmd_ready && !cmd_valid |=> cmd_ready)
    else $error("ready dropped without a request");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result pending after reset");

endmodule

bind toroidal_life_generation_engine tlge_checker u_tlge_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_col   (res.out_col),
  .res_bits  (res.col_bits),
  .res_last  (res.last)
);
`default_nettype wire
